// ===== rtl/core/sahrp_pkg.sv =====
package sahrp_pkg;

	// Number of axes kept by the block and the width of one axis value.
	localparam int unsigned AXIS_COUNT = 6;
	localparam int unsigned AXIS_W     = 16;

	// Width of the button bitmap as it is gathered from report bytes 1 to 4.
	localparam int unsigned BTN_W = 32;

	// Position of the last byte of a report in each format.
	localparam logic [3:0] LAST_POS_FMT0 = 4'd6;
	localparam logic [3:0] LAST_POS_FMT1 = 4'd12;

	// Number of axis pairs a report carries in each format.
	localparam logic [2:0] PAIRS_FMT0 = 3'd3;
	localparam logic [2:0] PAIRS_FMT1 = 3'd6;

	// First axis slot of a rotation report in format 0.
	localparam logic [2:0] ROT_BASE = 3'd3;

	// Reciprocal of 13 scaled by 2**16, exact for every 10-bit packet length.
	localparam logic [22:0] RECIP_13 = 23'd5042;

	// Report type codes carried in byte 0 of a report.
	localparam logic [7:0] TYPE_TRANSLATION = 8'h01;
	localparam logic [7:0] TYPE_ROTATION    = 8'h02;
	localparam logic [7:0] TYPE_BUTTONS     = 8'h03;
	localparam logic [7:0] TYPE_IGNORED     = 8'h17;

	// Configuration register indexes.
	localparam logic [1:0] CFG_REPORT_FORMAT = 2'd0;
	localparam logic [1:0] CFG_BUTTON_COUNT  = 2'd1;
	localparam logic [1:0] CFG_FULL_SCALE    = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [5:0]  BUTTON_COUNT_RESET = 6'd2;
	localparam logic [14:0] FULL_SCALE_RESET   = 15'd400;

	typedef enum logic [2:0] {
		KIND_TRANSLATION = 3'd0,
		KIND_ROTATION    = 3'd1,
		KIND_SIX_AXIS    = 3'd2,
		KIND_BUTTONS     = 3'd3,
		KIND_IGNORED     = 3'd4,
		KIND_UNKNOWN     = 3'd5
	} kind_t;

	typedef logic [AXIS_COUNT-1:0][AXIS_W-1:0] axes_t;

	// One result beat.
	typedef struct packed {
		axes_t              axes;
		logic [BTN_W-1:0]   buttons;
		kind_t              kind;
	} result_t;

	// Build a signed little-endian axis value and clamp it to +/- full scale.
	// A full scale of zero behaves as one.
	function automatic logic [AXIS_W-1:0] clamp_axis(
		input logic [7:0]  lo,
		input logic [7:0]  hi,
		input logic [14:0] full_scale
	);
		logic signed [16:0] v;
		logic signed [16:0] fs;
		logic signed [16:0] r;
		v  = 17'($signed({hi, lo}));
		fs = $signed({2'b00, (full_scale == 15'd0) ? 15'd1 : full_scale});
		if (v < -fs) begin
			r = -fs;
		end else if (v > fs) begin
			r = fs;
		end else begin
			r = v;
		end
		return r[AXIS_W-1:0];
	endfunction

endpackage

// ===== rtl/core/six_axis_hid_report_parser_core.sv =====
// Six-axis controller report parser.
//
// Input channel: one packet byte per beat (data_byte, packet_first,
// packet_last, packet_length), moved when in_valid is high and in_stall low.
// Output channel: one result beat per completed report with the six stored
// clamped axes, the stored button bitmap and the report kind.
// Configuration: cfg_write with cfg_index and cfg_data, to be written only while
// the block is idle; the user must keep to this, the block does not enforce it.
//
// Throughput is one byte per cycle while in_stall is low. The byte that completes
// a report (or the final byte of a short format 0 packet) goes into the output
// register, or into the skid register while the output is stalled. All decode,
// clamp and mask logic sits between the state registers and the output register.
//
// Reset restores the default configuration and clears all stored axes,
// buttons and parser state; no result is pending afterwards.
// When the receiver stalls, the output register holds its beat and one skid
// register absorbs the next result; in_stall rises only while the skid
// register is occupied.
module six_axis_hid_report_parser_core
	import sahrp_pkg::*;
#(
	parameter int unsigned MAX_BUTTONS = 32
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [14:0]        cfg_data,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               packet_first,
	input  logic               packet_last,
	input  logic [9:0]         packet_length,

	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] axis_x,
	output logic signed [15:0] axis_y,
	output logic signed [15:0] axis_z,
	output logic signed [15:0] axis_rx,
	output logic signed [15:0] axis_ry,
	output logic signed [15:0] axis_rz,
	output logic [31:0]        button_state,
	output logic [2:0]         report_kind
);

	// Configuration registers.
	logic        report_format_q;
	logic [5:0]  button_count_q;
	logic [14:0] full_scale_q;

	// Parser state.
	axes_t                  axis_store_q;
	axes_t                  stage_axis_q;
	logic [MAX_BUTTONS-1:0] button_store_q;
	logic [BTN_W-1:0]       stage_buttons_q;
	logic [3:0]             byte_pos_q;
	logic [7:0]             current_type_q;
	logic [7:0]             low_hold_q;
	logic                   packet_drop_q;
	logic                   past_first_q;

	// Output register and skid register.
	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;

	logic accept;
	assign accept   = in_valid && !in_stall;
	assign in_stall = skid_valid_q;

	// Length check for format 1: packet_length must be a multiple of 13.
	logic [22:0] plen_prod;
	logic [6:0]  plen_quot;
	logic [9:0]  plen_back;
	logic        len_bad;
	assign plen_prod = 23'(packet_length) * RECIP_13;
	assign plen_quot = plen_prod[22:16];
	assign plen_back = 10'({plen_quot, 3'b000}) + 10'({plen_quot, 2'b00}) + 10'(plen_quot);
	assign len_bad   = plen_back != packet_length;

	// State as seen by this byte once packet_first has been applied.
	logic       drop_eff;
	logic       past_first_eff;
	logic [3:0] pos_eff;
	logic [7:0] type_eff;
	assign drop_eff       = packet_first ? (report_format_q && len_bad) : packet_drop_q;
	assign past_first_eff = packet_first ? 1'b0 : past_first_q;
	assign pos_eff        = packet_first ? 4'd0 : byte_pos_q;
	assign type_eff       = (pos_eff == 4'd0) ? data_byte : current_type_q;

	// Report completion, either by length or by padding a short first report.
	logic full_report;
	logic pad_report;
	logic finish;
	assign full_report = pos_eff >= (report_format_q ? LAST_POS_FMT1 : LAST_POS_FMT0);
	assign pad_report  = !full_report && packet_last && !report_format_q && !past_first_eff;
	assign finish      = !drop_eff && (full_report || pad_report);

	// Which axis slots the current report type writes.
	logic base_valid;
	logic base_hi;
	always_comb begin
		base_valid = 1'b0;
		base_hi    = 1'b0;
		if (!report_format_q) begin
			if (type_eff == TYPE_TRANSLATION) begin
				base_valid = 1'b1;
			end else if (type_eff == TYPE_ROTATION) begin
				base_valid = 1'b1;
				base_hi    = 1'b1;
			end
		end else if (type_eff == TYPE_TRANSLATION) begin
			base_valid = 1'b1;
		end
	end

	// Axis pair addressing for this byte.
	logic [3:0] pos_m1;
	logic [2:0] pair_idx;
	logic       axis_byte;
	logic       low_byte;
	logic [2:0] slot;
	assign pos_m1    = pos_eff - 4'd1;
	assign pair_idx  = pos_m1[3:1];
	assign low_byte  = pos_eff[0];
	assign axis_byte = (pos_eff != 4'd0) && base_valid &&
		(pair_idx < (report_format_q ? PAIRS_FMT1 : PAIRS_FMT0));
	assign slot      = (base_hi ? ROT_BASE : 3'd0) + pair_idx;

	logic [AXIS_W-1:0] clamp_full;
	logic [AXIS_W-1:0] clamp_pad;
	assign clamp_full = clamp_axis(low_hold_q, data_byte, full_scale_q);
	assign clamp_pad  = clamp_axis(data_byte, 8'h00, full_scale_q);

	// Button mask from the configured count; bits beyond the store never exist.
	logic [MAX_BUTTONS-1:0] button_mask;
	always_comb begin
		for (int i = 0; i < MAX_BUTTONS; i++) begin
			button_mask[i] = button_count_q > 6'(i);
		end
	end

	// Next staging values, committed stores and the result beat.
	axes_t                  stage_axis_n;
	axes_t                  axis_store_n;
	logic [BTN_W-1:0]       stage_buttons_n;
	logic [MAX_BUTTONS-1:0] button_store_n;
	logic [7:0]             low_hold_n;
	kind_t                  kind_n;
	result_t                result_n;
	always_comb begin
		for (int i = 0; i < AXIS_COUNT; i++) begin
			stage_axis_n[i] = (pos_eff == 4'd0) ? '0 : stage_axis_q[i];
			if (axis_byte && (slot == 3'(i))) begin
				if (!low_byte) begin
					stage_axis_n[i] = clamp_full;
				end else if (pad_report) begin
					stage_axis_n[i] = clamp_pad;
				end
			end
			if (base_valid && (report_format_q || ((i >= 3) == base_hi))) begin
				axis_store_n[i] = stage_axis_n[i];
			end else begin
				axis_store_n[i] = axis_store_q[i];
			end
		end

		if (pos_eff == 4'd0) begin
			low_hold_n = 8'h00;
		end else if (axis_byte && low_byte) begin
			low_hold_n = data_byte;
		end else begin
			low_hold_n = low_hold_q;
		end

		stage_buttons_n = (pos_eff == 4'd0) ? '0 : stage_buttons_q;
		if (type_eff == TYPE_BUTTONS && pos_eff >= 4'd1 && pos_eff <= 4'd4) begin
			stage_buttons_n = stage_buttons_n |
				(BTN_W'(data_byte) << {pos_m1[1:0], 3'b000});
		end
		if (type_eff == TYPE_BUTTONS) begin
			button_store_n = stage_buttons_n[MAX_BUTTONS-1:0] & button_mask;
		end else begin
			button_store_n = button_store_q;
		end

		priority if (type_eff == TYPE_BUTTONS) begin
			kind_n = KIND_BUTTONS;
		end else if (!report_format_q && type_eff == TYPE_TRANSLATION) begin
			kind_n = KIND_TRANSLATION;
		end else if (!report_format_q && type_eff == TYPE_ROTATION) begin
			kind_n = KIND_ROTATION;
		end else if (report_format_q && type_eff == TYPE_TRANSLATION) begin
			kind_n = KIND_SIX_AXIS;
		end else if (report_format_q && type_eff == TYPE_IGNORED) begin
			kind_n = KIND_IGNORED;
		end else begin
			kind_n = KIND_UNKNOWN;
		end

		result_n.axes    = axis_store_n;
		result_n.buttons = BTN_W'(button_store_n);
		result_n.kind    = kind_n;
	end

	logic produce;
	assign produce = accept && finish;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_format_q <= 1'b0;
			button_count_q  <= BUTTON_COUNT_RESET;
			full_scale_q    <= FULL_SCALE_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_REPORT_FORMAT: report_format_q <= cfg_data[0];
				CFG_BUTTON_COUNT:  button_count_q  <= cfg_data[5:0];
				CFG_FULL_SCALE:    full_scale_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Parser state update on each accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_store_q    <= '0;
			stage_axis_q    <= '0;
			button_store_q  <= '0;
			stage_buttons_q <= '0;
			byte_pos_q      <= 4'd0;
			current_type_q  <= 8'h00;
			low_hold_q      <= 8'h00;
			packet_drop_q   <= 1'b0;
			past_first_q    <= 1'b0;
		end else if (accept) begin
			if (!drop_eff) begin
				stage_axis_q    <= stage_axis_n;
				stage_buttons_q <= stage_buttons_n;
				low_hold_q      <= low_hold_n;
				current_type_q  <= type_eff;
			end
			if (finish) begin
				axis_store_q   <= axis_store_n;
				button_store_q <= button_store_n;
			end
			if (packet_last) begin
				byte_pos_q    <= 4'd0;
				packet_drop_q <= 1'b0;
				past_first_q  <= 1'b0;
			end else begin
				packet_drop_q <= drop_eff;
				past_first_q  <= finish ? 1'b1 : past_first_eff;
				if (drop_eff) begin
					byte_pos_q <= pos_eff;
				end else begin
					byte_pos_q <= finish ? 4'd0 : pos_eff + 4'd1;
				end
			end
		end
	end

	// Output register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= produce;
			end
		end else if (produce) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (produce) begin
				out_q <= result_n;
			end
		end else if (produce) begin
			skid_q <= result_n;
		end
	end

	assign out_valid    = out_valid_q;
	assign axis_x       = out_q.axes[0];
	assign axis_y       = out_q.axes[1];
	assign axis_z       = out_q.axes[2];
	assign axis_rx      = out_q.axes[3];
	assign axis_ry      = out_q.axes[4];
	assign axis_rz      = out_q.axes[5];
	assign button_state = out_q.buttons;
	assign report_kind  = out_q.kind;

	// The skid entry is only ever filled behind a held output beat.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid without an output beat");

	// The skid entry fills only when the output was stalled.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall))
		else $error("skid entry filled while output was free");

	// The report position never runs past the longest report.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_pos_q <= LAST_POS_FMT1)
		else $error("byte position beyond report length");

	// The final byte of a packet leaves the parser at a clean report start.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && packet_last) |=> (byte_pos_q == 4'd0 && !packet_drop_q && !past_first_q))
		else $error("packet end did not clear parser state");

endmodule

// ===== verif/six_axis_hid_report_parser_core_tb.sv =====
module six_axis_hid_report_parser_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sahrp_pkg::*;

	localparam int HALF_PERIOD   = 10;
	localparam int IDLE_PCT      = 38;
	localparam int QUIET_LIMIT   = 2000;
	localparam int RANDOM_ITEMS  = 800;

	// One row of the directed script: either a register setting or one packet byte.
	typedef struct {
		bit          is_cfg;
		bit          fmt;
		bit [5:0]    cnt;
		bit [14:0]   scale;
		bit [7:0]    data;
		bit          is_first;
		bit          is_last;
		bit [9:0]    plen;
		bit          pinned;
		result_t     want;
	} script_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_write = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [14:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         data_byte = '0;
	logic               packet_first = 1'b0;
	logic               packet_last = 1'b0;
	logic [9:0]         packet_length = 10'd1;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [15:0] axis_x;
	logic signed [15:0] axis_y;
	logic signed [15:0] axis_z;
	logic signed [15:0] axis_rx;
	logic signed [15:0] axis_ry;
	logic signed [15:0] axis_rz;
	logic [31:0]        button_state;
	logic [2:0]         report_kind;

	// Typed-in expectation that travels with the byte being driven.
	bit      pinned_valid = 1'b0;
	result_t pinned_want = '0;

	// Sender and receiver never idle while this is set.
	bit calm = 1'b0;

	result_t     reports_due[$];
	script_row_t script[$];
	int          mismatch_count = 0;
	int          quiet_cycles = 0;
	int          sent_items = 0;
	bit          fmt_now = 1'b0;

	// Shadow of the parser: configuration and decode state.
	bit                 shadow_fmt = 1'b0;
	bit [5:0]           shadow_count = BUTTON_COUNT_RESET;
	bit [14:0]          shadow_scale = FULL_SCALE_RESET;
	logic signed [15:0] axis_keep[AXIS_COUNT] = '{default: '0};
	logic signed [15:0] axis_stage[AXIS_COUNT] = '{default: '0};
	bit [31:0]          btn_keep = '0;
	bit [31:0]          btn_stage = '0;
	int unsigned        byte_pos = 0;
	bit [7:0]           rpt_type = '0;
	bit [7:0]           lo_hold = '0;
	bit                 dropping = 1'b0;
	bit                 first_done = 1'b0;

	string axis_label[AXIS_COUNT] = '{"axis_x", "axis_y", "axis_z",
		"axis_rx", "axis_ry", "axis_rz"};

	six_axis_hid_report_parser_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.packet_first (packet_first),
		.packet_last  (packet_last),
		.packet_length(packet_length),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.axis_x       (axis_x),
		.axis_y       (axis_y),
		.axis_z       (axis_z),
		.axis_rx      (axis_rx),
		.axis_ry      (axis_ry),
		.axis_rz      (axis_rz),
		.button_state (button_state),
		.report_kind  (report_kind)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// The receiver stalls at random except during the calm stretch.
	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
	end

	task automatic note_mismatch(input string what, input logic [31:0] seen,
		input logic [31:0] wanted);
		$display("%0t mismatch on %s: got %h, expected %h", $realtime, what, seen, wanted);
		mismatch_count++;
	endtask

	// First axis slot the current report writes, or -1 when it carries no axes.
	function automatic int axis_base_of();
		if (!shadow_fmt) begin
			if (rpt_type == TYPE_TRANSLATION) begin
				return 0;
			end
			if (rpt_type == TYPE_ROTATION) begin
				return ROT_BASE;
			end
			return -1;
		end
		return (rpt_type == TYPE_TRANSLATION) ? 0 : -1;
	endfunction

	// Stage one report byte at position pos (1 or more).
	task automatic stage_byte(input int unsigned pos, input bit [7:0] b);
		int base;
		int idx;
		int pairs;
		int v;
		int lim;
		base = axis_base_of();
		if (base >= 0) begin
			idx = (pos - 1) >> 1;
			pairs = shadow_fmt ? 6 : 3;
			if (idx < pairs) begin
				if (((pos - 1) & 1) == 0) begin
					lo_hold = b;
				end else begin
					v = $signed({b, lo_hold});
					lim = (shadow_scale == 0) ? 1 : int'(shadow_scale);
					if (v < -lim) begin
						v = -lim;
					end
					if (v > lim) begin
						v = lim;
					end
					axis_stage[base + idx] = 16'(v);
				end
			end
		end
		if (rpt_type == TYPE_BUTTONS && pos <= 4) begin
			btn_stage |= 32'(b) << (8 * (pos - 1));
		end
	endtask

	// Commit the staged report to the stores and form the result beat.
	task automatic commit_report(output result_t r);
		int base;
		int cnt;
		int n;
		bit [31:0] mask;
		base = axis_base_of();
		cnt = shadow_fmt ? 6 : 3;
		n = (shadow_count > 32) ? 32 : int'(shadow_count);
		mask = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
		if (base >= 0) begin
			for (int i = 0; i < cnt; i++) begin
				axis_keep[base + i] = axis_stage[base + i];
			end
		end
		if (rpt_type == TYPE_BUTTONS) begin
			btn_keep = btn_stage & mask;
		end
		for (int i = 0; i < AXIS_COUNT; i++) begin
			r.axes[i] = axis_keep[i];
		end
		r.buttons = btn_keep;
		if (rpt_type == TYPE_BUTTONS) begin
			r.kind = KIND_BUTTONS;
		end else if (!shadow_fmt) begin
			r.kind = (rpt_type == TYPE_TRANSLATION) ? KIND_TRANSLATION :
				(rpt_type == TYPE_ROTATION) ? KIND_ROTATION : KIND_UNKNOWN;
		end else begin
			r.kind = (rpt_type == TYPE_TRANSLATION) ? KIND_SIX_AXIS :
				(rpt_type == TYPE_IGNORED) ? KIND_IGNORED : KIND_UNKNOWN;
		end
		first_done = 1'b1;
	endtask

	// Advance the shadow parser by one accepted byte.
	task automatic decode_byte(input bit [7:0] b, input bit is_first, input bit is_last,
		input bit [9:0] plen, output bit emitted, output result_t r);
		int unsigned len;
		int unsigned p;
		len = shadow_fmt ? 13 : 7;
		emitted = 1'b0;
		r = '0;
		if (is_first) begin
			byte_pos = 0;
			first_done = 1'b0;
			dropping = shadow_fmt && (plen % 13 != 0);
		end
		if (!dropping) begin
			p = byte_pos;
			if (p == 0) begin
				rpt_type = b;
				lo_hold = '0;
				btn_stage = '0;
				axis_stage = '{default: '0};
			end else begin
				stage_byte(p, b);
			end
			if (p + 1 >= len) begin
				commit_report(r);
				emitted = 1'b1;
				byte_pos = 0;
			end else begin
				byte_pos = p + 1;
				// A short first report in format 0 is padded out with zero bytes.
				if (is_last && !shadow_fmt && !first_done) begin
					for (int unsigned q = byte_pos; q < len; q++) begin
						stage_byte(q, 8'h00);
					end
					commit_report(r);
					emitted = 1'b1;
					byte_pos = 0;
				end
			end
		end
		if (is_last) begin
			byte_pos = 0;
			dropping = 1'b0;
			first_done = 1'b0;
		end
	endtask

	// Sample both channels and the register port at each rising edge.
	always @(posedge clk) begin : scoreboard
		result_t got;
		result_t want;
		result_t calc;
		bit emitted;
		bit active;
		if (arst_n) begin
			active = 1'b0;
			if (out_valid && !out_stall) begin
				active = 1'b1;
				if (reports_due.size() == 0) begin
					note_mismatch("result beat with nothing pending", {29'd0, report_kind}, '0);
				end else begin
					want = reports_due.pop_front();
					got.axes = {axis_rz, axis_ry, axis_rx, axis_z, axis_y, axis_x};
					got.buttons = button_state;
					got.kind = kind_t'(report_kind);
					for (int i = 0; i < AXIS_COUNT; i++) begin
						if (got.axes[i] !== want.axes[i]) begin
							note_mismatch(axis_label[i], 32'(got.axes[i]), 32'(want.axes[i]));
						end
					end
					if (got.buttons !== want.buttons) begin
						note_mismatch("button_state", got.buttons, want.buttons);
					end
					if (got.kind !== want.kind) begin
						note_mismatch("report_kind", 32'(got.kind), 32'(want.kind));
					end
				end
			end
			if (cfg_write) begin
				active = 1'b1;
				case (cfg_index)
					CFG_REPORT_FORMAT: shadow_fmt = cfg_data[0];
					CFG_BUTTON_COUNT:  shadow_count = cfg_data[5:0];
					CFG_FULL_SCALE:    shadow_scale = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				active = 1'b1;
				decode_byte(data_byte, packet_first, packet_last, packet_length, emitted, calc);
				if (pinned_valid) begin
					reports_due.push_back(pinned_want);
				end else if (emitted) begin
					reports_due.push_back(calc);
				end
			end
			quiet_cycles = active ? 0 : quiet_cycles + 1;
		end
	end

	// Give up when nothing has moved for too long.
	initial begin : watchdog
		while (quiet_cycles < QUIET_LIMIT) begin
			@(negedge clk);
		end
		$display("six_axis_hid_report_parser_core_tb NOT OK");
		$finish;
	end

	function automatic result_t make_result(input int x, input int y, input int z,
		input int rx, input int ry, input int rz, input bit [31:0] btn, input kind_t k);
		result_t r;
		r.axes[0] = 16'(x);
		r.axes[1] = 16'(y);
		r.axes[2] = 16'(z);
		r.axes[3] = 16'(rx);
		r.axes[4] = 16'(ry);
		r.axes[5] = 16'(rz);
		r.buttons = btn;
		r.kind = k;
		return r;
	endfunction

	function automatic bit [7:0] pick_type();
		case ($urandom_range(0, 9))
			0, 1, 2: return TYPE_TRANSLATION;
			3, 4:    return TYPE_ROTATION;
			5, 6:    return TYPE_BUTTONS;
			7:       return TYPE_IGNORED;
			8:       return 8'h00;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Payload bytes lean toward the sign and clamp boundaries.
	function automatic bit [7:0] pick_data();
		if ($urandom_range(0, 2) == 0) begin
			case ($urandom_range(0, 7))
				0: return 8'h00;
				1: return 8'h01;
				2: return 8'h7F;
				3: return 8'h80;
				4: return 8'hFE;
				5: return 8'hFF;
				6: return 8'h90;
				default: return 8'h70;
			endcase
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// Offer one byte, idling first at random, and hold it until accepted.
	task automatic drive_byte(input bit [7:0] b, input bit is_first, input bit is_last,
		input bit [9:0] plen, input bit pin, input result_t want);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		packet_first <= is_first;
		packet_last <= is_last;
		packet_length <= plen;
		pinned_valid <= pin;
		pinned_want <= want;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sent_items++;
		@(negedge clk);
	endtask

	// Stop sending and wait until every pending result beat has been seen.
	task automatic settle();
		in_valid <= 1'b0;
		while (reports_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	// Write all three registers; upper data bits of narrow registers carry noise.
	task automatic apply_config(input bit fmt, input bit [5:0] cnt, input bit [14:0] scale);
		cfg_write <= 1'b1;
		cfg_index <= CFG_REPORT_FORMAT;
		cfg_data <= 15'({$urandom_range(0, 16383), fmt});
		@(negedge clk);
		cfg_index <= CFG_BUTTON_COUNT;
		cfg_data <= 15'({$urandom_range(0, 511), cnt});
		@(negedge clk);
		cfg_index <= CFG_FULL_SCALE;
		cfg_data <= scale;
		@(negedge clk);
		cfg_write <= 1'b0;
		fmt_now = fmt;
	endtask

	// Send one packet: mostly whole reports, sometimes noise. A cut packet stops early.
	task automatic send_packet(input bit cut);
		bit [7:0] bytes_q[$];
		bit well;
		bit keep_first;
		bit keep_last;
		bit f;
		bit l;
		int rl;
		int stop;
		bit [9:0] plen;
		well = $urandom_range(0, 99) < 80;
		rl = fmt_now ? 13 : 7;
		if (well) begin
			if (!fmt_now && $urandom_range(0, 4) == 0) begin
				bytes_q.push_back(pick_type());
				repeat ($urandom_range(0, 5)) bytes_q.push_back(pick_data());
			end else begin
				repeat ($urandom_range(1, 3)) begin
					bytes_q.push_back(pick_type());
					repeat (rl - 1) bytes_q.push_back(pick_data());
				end
			end
			plen = 10'(bytes_q.size());
			// A trailing partial report that must be thrown away.
			if ($urandom_range(0, 5) == 0) begin
				bytes_q.push_back(pick_type());
				repeat ($urandom_range(0, rl - 2)) bytes_q.push_back(pick_data());
			end
			keep_first = 1'b1;
			keep_last = 1'b1;
		end else begin
			repeat ($urandom_range(1, 30)) begin
				bytes_q.push_back(($urandom_range(0, 3) == 0) ? pick_type() : pick_data());
			end
			plen = 10'($urandom_range(1, 1023));
			keep_first = $urandom_range(0, 3) != 0;
			keep_last = $urandom_range(0, 3) != 0;
		end
		stop = cut ? $urandom_range(1, bytes_q.size()) : bytes_q.size();
		for (int i = 0; i < stop; i++) begin
			f = (i == 0 && keep_first) || (!well && $urandom_range(0, 19) == 0);
			l = (i == bytes_q.size() - 1 && keep_last) || (!well && $urandom_range(0, 19) == 0);
			drive_byte(bytes_q[i], f, l, plen, 1'b0, '0);
		end
	endtask

	task automatic add_byte(input bit [7:0] b, input bit is_first, input bit is_last,
		input bit [9:0] plen, input bit pin = 1'b0, input result_t want = '0);
		script_row_t row;
		row = '{default: '0};
		row.data = b;
		row.is_first = is_first;
		row.is_last = is_last;
		row.plen = plen;
		row.pinned = pin;
		row.want = want;
		script.push_back(row);
	endtask

	initial begin : stimulus
		script_row_t row;
		int phase_no;
		int random_goal;
		int burst;
		bit [5:0] cnt;
		bit [14:0] scale;

		// Reset-value configuration: format 0, two buttons, full scale 400.
		// Short translation packet with both axis extremes, padded with zeros.
		add_byte(TYPE_TRANSLATION, 1, 0, 10'd5);
		add_byte(8'hFF, 0, 0, 10'd5);
		add_byte(8'h7F, 0, 0, 10'd5);
		add_byte(8'h00, 0, 0, 10'd5);
		add_byte(8'h80, 0, 1, 10'd5, 1,
			make_result(400, -400, 0, 0, 0, 0, 32'd0, KIND_TRANSLATION));
		// One-byte rotation packet, all rotation axes padded to zero.
		add_byte(TYPE_ROTATION, 1, 1, 10'd1, 1,
			make_result(400, -400, 0, 0, 0, 0, 32'd0, KIND_ROTATION));
		// Short button packet, all ones masked to two buttons.
		add_byte(TYPE_BUTTONS, 1, 0, 10'd5);
		add_byte(8'hFF, 0, 0, 10'd5);
		add_byte(8'hFF, 0, 0, 10'd5);
		add_byte(8'hFF, 0, 0, 10'd5);
		add_byte(8'hFF, 0, 1, 10'd5, 1,
			make_result(400, -400, 0, 0, 0, 0, 32'd3, KIND_BUTTONS));
		// Ignored type in format 0 is unknown; also a packet with no first flag.
		add_byte(TYPE_IGNORED, 0, 1, 10'd1, 1,
			make_result(400, -400, 0, 0, 0, 0, 32'd3, KIND_UNKNOWN));
		// Format 1, saturated button count, zero full scale acting as one.
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.fmt = 1'b1;
		row.cnt = 6'd63;
		row.scale = 15'd0;
		script.push_back(row);
		// Bad length in format 1: dropped without a result.
		add_byte(TYPE_TRANSLATION, 1, 1, 10'd5);
		// Six-axis report with extremes, then a trailing partial report.
		add_byte(TYPE_TRANSLATION, 1, 0, 10'd26);
		add_byte(8'hFF, 0, 0, 10'd26);
		add_byte(8'h7F, 0, 0, 10'd26);
		add_byte(8'h00, 0, 0, 10'd26);
		add_byte(8'h80, 0, 0, 10'd26);
		add_byte(8'h01, 0, 0, 10'd26);
		add_byte(8'h00, 0, 0, 10'd26);
		add_byte(8'hFF, 0, 0, 10'd26);
		add_byte(8'hFF, 0, 0, 10'd26);
		add_byte(8'h00, 0, 0, 10'd26);
		add_byte(8'h00, 0, 0, 10'd26);
		add_byte(8'h02, 0, 0, 10'd26);
		add_byte(8'h00, 0, 0, 10'd26, 1,
			make_result(1, -1, 1, -1, 0, 1, 32'd3, KIND_SIX_AXIS));
		add_byte(TYPE_BUTTONS, 0, 1, 10'd26);

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				settle();
				apply_config(script[i].fmt, script[i].cnt, script[i].scale);
			end else begin
				drive_byte(script[i].data, script[i].is_first, script[i].is_last,
					script[i].plen, script[i].pinned, script[i].want);
			end
		end

		// Random phases, each under its own register setting, the first ones at the extremes.
		phase_no = 0;
		random_goal = sent_items + RANDOM_ITEMS;
		while (sent_items < random_goal) begin
			settle();
			case (phase_no)
				0: apply_config(1'b0, 6'd0, 15'd1);
				1: apply_config(1'b1, 6'd32, 15'h7FFF);
				2: apply_config(1'b0, 6'd33, 15'd0);
				default: begin
					case ($urandom_range(0, 4))
						0: cnt = 6'd0;
						1: cnt = 6'd32;
						2: cnt = 6'd2;
						default: cnt = 6'($urandom_range(0, 63));
					endcase
					case ($urandom_range(0, 5))
						0: scale = 15'd1;
						1: scale = 15'h7FFF;
						2: scale = 15'd400;
						3: scale = 15'd350;
						default: scale = 15'($urandom_range(0, 32767));
					endcase
					apply_config(1'($urandom_range(0, 1)), cnt, scale);
				end
			endcase
			calm <= (phase_no == 3);
			phase_no++;
			burst = $urandom_range(40, 120);
			for (int n = sent_items + burst; sent_items < n; ) begin
				send_packet(1'b0);
			end
			// Leave a packet open so the next setting lands in mid-report.
			if ($urandom_range(0, 1) == 1) begin
				send_packet(1'b1);
			end
		end

		settle();
		repeat (8) @(negedge clk);
		if (mismatch_count == 0 && reports_due.size() == 0) begin
			$display("six_axis_hid_report_parser_core_tb OK");
		end else begin
			$display("six_axis_hid_report_parser_core_tb NOT OK");
		end
		$finish;
	end

endmodule
